// File: rtl/rvmem_pkg.sv
// rvmem_pkg: opcodes, access codes and sequencer types for the data memory stage
// used by rvmem_seq and riscv_data_memory_stage
// no dependencies
package rvmem_pkg;

	// major opcodes, instruction bits 6:0
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_NONE   = 7'b0000000;

	// funct3 access sizes, instruction bits 14:12
	localparam logic [2:0] F3_HALF  = 3'b001;
	localparam logic [2:0] F3_WORD  = 3'b010;
	localparam logic [2:0] F3_BYTEU = 3'b100;

	localparam logic [7:0]  BYTE_MASK = 8'hFF;
	localparam logic [31:0] NO_LOAD   = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_WRITE,
		ST_FINISH
	} seq_state_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_STORE
	} acc_kind_t;

	// datapath to sequencer: a new item and what it does
	typedef struct packed {
		logic      start;
		acc_kind_t kind;
		logic [1:0] last_lane;
	} seq_req_t;

	// sequencer to datapath: memory strobes and result timing
	typedef struct packed {
		logic       ready;
		logic       clr;
		logic       rd;
		logic       wr;
		logic [1:0] lane;
		logic       finish;
	} seq_ctl_t;

endpackage

// File: rtl/rvmem_ram.sv
// rvmem_ram: generic single-port synchronous RAM with registered read data
// no dependencies
module rvmem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// File: rtl/rvmem_seq.sv
// rvmem_seq: sequencer for the byte-serial memory access and the clearing pass
// depends on rvmem_pkg
module rvmem_seq import rvmem_pkg::*; #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  seq_req_t                     req,
	input  logic                         out_free,
	output seq_ctl_t                     ctl,
	output logic [$clog2(MEM_BYTES)-1:0] clr_idx
);

	localparam int AW = $clog2(MEM_BYTES);

	seq_state_t  state_q, state_n;
	logic [1:0]  lane_q;
	logic [1:0]  last_q;
	logic [AW-1:0] clr_q;

	assign clr_idx = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			lane_q  <= 2'd0;
			last_q  <= 2'd0;
			clr_q   <= '0;
		end else begin
			state_q <= state_n;
			if (ctl.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (req.start) begin
				lane_q <= 2'd0;
				last_q <= req.last_lane;
			end else if (ctl.rd || ctl.wr) begin
				lane_q <= lane_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		ctl     = '0;
		ctl.lane = lane_q;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr = 1'b1;
				if (clr_q == AW'(MEM_BYTES - 1)) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ctl.ready = 1'b1;
				if (req.start) begin
					case (req.kind)
						ACC_LOAD:  state_n = ST_READ;
						ACC_STORE: state_n = ST_WRITE;
						default:   state_n = ST_FINISH;
					endcase
				end
			end
			ST_READ: begin
				ctl.rd = 1'b1;
				if (lane_q == last_q) begin
					state_n = ST_DRAIN;
				end
			end
			// last read byte lands in the accumulator here
			ST_DRAIN: begin
				state_n = ST_FINISH;
			end
			ST_WRITE: begin
				ctl.wr = 1'b1;
				if (lane_q == last_q) begin
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					ctl.finish = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/riscv_data_memory_stage.sv
// riscv_data_memory_stage: top level of the load/store memory stage
// depends on rvmem_pkg, rvmem_ram and rvmem_seq
//
// One instruction beat in gives one result beat out. Memory is one byte-wide
// synchronous RAM of MEM_BYTES entries, so an access moves one byte per cycle.
// Bytes move for SH, LBU, SW and LW, and a finished access waits while the
// result register waits on m_tready. After reset the RAM is zeroed, one byte
// a cycle, which keeps s_tready low until every entry is cleared. Byte addresses
// wrap modulo MEM_BYTES. A beat is taken while the previous result still waits.
module riscv_data_memory_stage import rvmem_pkg::*; #(
	parameter int MEM_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // instruction[31:0], address[43:32], store_data[75:44], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // load_data[31:0]
	output logic        m_tuser   // loaded[0]
);

	localparam int AW = $clog2(MEM_BYTES);

	seq_req_t req;
	seq_ctl_t ctl;
	logic [AW-1:0] clr_idx;

	logic        accept;
	logic [31:0] instruction;
	logic [11:0] address;
	logic [31:0] store_data;
	logic [6:0]  opcode;
	logic [2:0]  funct3;
	logic        re_n, we_n;
	logic        re_q, we_q;
	acc_kind_t   kind_n, kind_q;
	logic [1:0]  last_n;

	logic [AW-1:0] cur_q;
	logic [31:0]   data_q;
	logic [31:0]   acc_q;
	logic          rd_s1;
	logic [1:0]    lane_s1;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	logic [7:0]    wr_byte;
	logic          out_free;

	// address reduced below MEM_BYTES by compare and subtract of scaled sizes
	function automatic logic [AW-1:0] wrap_addr(input logic [11:0] a);
		logic [11:0] r;
		r = a;
		for (int k = 7; k >= 0; k--) begin
			if ((MEM_BYTES << k) <= 4095) begin
				if (r >= 12'(MEM_BYTES << k)) begin
					r = r - 12'(MEM_BYTES << k);
				end
			end
		end
		return AW'(r);
	endfunction

	assign instruction = s_tdata[31:0];
	assign address     = s_tdata[43:32];
	assign store_data  = s_tdata[75:44];
	assign opcode      = instruction[6:0];
	assign funct3      = instruction[14:12];

	assign s_tready = ctl.ready;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// enables persist across opcodes the stage does not know
	always_comb begin
		re_n = re_q;
		we_n = we_q;
		case (opcode)
			OPC_LOAD: begin
				re_n = 1'b1;
				we_n = 1'b0;
			end
			OPC_STORE: begin
				re_n = 1'b0;
				we_n = 1'b1;
			end
			OPC_OPIMM, OPC_LUI, OPC_OP, OPC_BRANCH, OPC_JALR, OPC_NONE: begin
				re_n = 1'b0;
				we_n = 1'b0;
			end
			default: begin
				re_n = re_q;
				we_n = we_q;
			end
		endcase
	end

	// store wins over load
	always_comb begin
		kind_n = ACC_NONE;
		last_n = 2'd0;
		if (we_n) begin
			if (funct3 == F3_HALF) begin
				kind_n = ACC_STORE;
				last_n = 2'd1;
			end else if (funct3 == F3_WORD) begin
				kind_n = ACC_STORE;
				last_n = 2'd3;
			end
		end else if (re_n) begin
			if (funct3 == F3_BYTEU) begin
				kind_n = ACC_LOAD;
				last_n = 2'd0;
			end else if (funct3 == F3_WORD) begin
				kind_n = ACC_LOAD;
				last_n = 2'd3;
			end
		end
	end

	always_comb begin
		req.start     = accept;
		req.kind      = kind_n;
		req.last_lane = last_n;
	end

	rvmem_seq #(
		.MEM_BYTES(MEM_BYTES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.out_free(out_free),
		.ctl     (ctl),
		.clr_idx (clr_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			re_q     <= 1'b0;
			we_q     <= 1'b0;
			kind_q   <= ACC_NONE;
			rd_s1    <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			rd_s1 <= ctl.rd;
			if (accept) begin
				re_q   <= re_n;
				we_q   <= we_n;
				kind_q <= kind_n;
			end
			if (ctl.finish) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= ctl.lane;
		if (accept) begin
			cur_q  <= wrap_addr(address);
			data_q <= store_data;
			acc_q  <= '0;
		end else begin
			if (ctl.rd || ctl.wr) begin
				cur_q <= (cur_q == AW'(MEM_BYTES - 1)) ? '0 : cur_q + 1'b1;
			end
			if (rd_s1) begin
				acc_q[{lane_s1, 3'b000} +: 8] <= ram_rdata & BYTE_MASK;
			end
		end
		if (ctl.finish) begin
			m_tdata <= (kind_q == ACC_LOAD) ? acc_q : NO_LOAD;
			m_tuser <= (kind_q == ACC_LOAD);
		end
	end

	assign wr_byte   = data_q[{ctl.lane, 3'b000} +: 8];
	assign ram_we    = ctl.clr || ctl.wr;
	assign ram_addr  = ctl.clr ? clr_idx : cur_q;
	assign ram_wdata = ctl.clr ? 8'd0 : wr_byte;

	rvmem_ram #(
		.WIDTH(8),
		.DEPTH(MEM_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ctl.rd),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

endmodule

// File: rtl/rvmem_chk.sv
// rvmem_chk: port-level checks for riscv_data_memory_stage, bound to the top level
// depends on riscv_data_memory_stage port names only
module rvmem_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// a result without a load reads all ones
	a_no_load_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'hFFFF_FFFF)
		else $error("non-load result is not all ones");

	// one instruction in flight: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// a new result appears as the stage turns idle again
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready && !$past(s_tready))
		else $error("result beat not aligned with end of access");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

endmodule

bind riscv_data_memory_stage rvmem_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
